### src/mctt_pkg.sv
// ----------------------------------------------------------------------------
// mctt_pkg: shared definitions of the multi-channel timer table
// Command codes, status codes and default sizes used by the front end, the
// back end and the top level.
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam int unsigned DefMaxEntries = 24;
  localparam int unsigned DefIdBits     = 8;
  localparam int unsigned DefCountBits  = 32;

  // Item kinds as they arrive on the input channel.
  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_STOP     = 3'd1;
  localparam logic [2:0] KIND_TICK     = 3'd2;
  localparam logic [2:0] KIND_DISPATCH = 3'd3;
  localparam logic [2:0] KIND_QUERY    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NULL_ID  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Classified commands passed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_START,
    OP_START_NULL,
    OP_STOP,
    OP_TICK,
    OP_DISPATCH,
    OP_QUERY,
    OP_QUERY_NULL,
    OP_NOP
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_EX   = 8'b0000_0100,
    S_RDL  = 8'b0000_1000,
    S_MV   = 8'b0001_0000,
    S_RES  = 8'b0010_0000,
    S_EMRD = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_e;

endpackage

### src/multi_channel_timer_table.sv
// ----------------------------------------------------------------------------
// multi_channel_timer_table: packed table of software timers with reload
// Top level joining the intake queue and the table engine.
// ----------------------------------------------------------------------------
// Usage: each input item carries a kind (start, stop, tick, dispatch, query),
// a timer id and, for start, a delay and a reload period. An item is taken
// when in_valid_i is high and in_stall_o is low; a result item leaves when
// out_valid_o is high and out_stall_i is low. Every input item gives one
// result, except a dispatch that finds expired timers, which gives one result per expired timer in
// table order; last_o marks the final result of an item.
// The engine walks the table one slot at a time through its single-port
// table memory, reading and then examining each occupied slot; a removal
// also reads the last slot and moves it into the vacated one, and a
// dispatch then replays the fired-id buffer. A two-entry queue sits in
// front, so up to two items are taken while the engine is busy.
// Reset clears the entry count, the queue and the result register; the table
// contents need no clearing since only occupied slots are ever read.
// When the receiver stalls, the result is held in the output register and
// the engine waits; the input queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module multi_channel_timer_table #(
  parameter int unsigned MAX_ENTRIES = mctt_pkg::DefMaxEntries,
  parameter int unsigned ID_BITS     = mctt_pkg::DefIdBits,
  parameter int unsigned COUNT_BITS  = mctt_pkg::DefCountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  timer_id_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] period_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  fired_id_o,
  output logic        present_o,
  output logic [1:0]  status_o,
  output logic [4:0]  active_count_o,
  output logic        last_o
);
  import mctt_pkg::*;

  logic                  cmd_valid, cmd_pop;
  op_e                   cmd_op;
  logic [ID_BITS-1:0]    cmd_id;
  logic [COUNT_BITS-1:0] cmd_delay, cmd_period;

  mctt_front #(
    .IdBits   (ID_BITS),
    .CountBits(COUNT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .timer_id_i    (timer_id_i),
    .delay_ticks_i (delay_ticks_i),
    .period_ticks_i(period_ticks_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop),
    .cmd_op_o      (cmd_op),
    .cmd_id_o      (cmd_id),
    .cmd_delay_o   (cmd_delay),
    .cmd_period_o  (cmd_period)
  );

  mctt_back #(
    .MaxEntries(MAX_ENTRIES),
    .IdBits    (ID_BITS),
    .CountBits (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .cmd_op_i      (cmd_op),
    .cmd_id_i      (cmd_id),
    .cmd_delay_i   (cmd_delay),
    .cmd_period_i  (cmd_period),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fired_id_o    (fired_id_o),
    .present_o     (present_o),
    .status_o      (status_o),
    .active_count_o(active_count_o),
    .last_o        (last_o)
  );

  // An error status always ends its item and never reports a fired timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && fired_id_o == 8'd0 && !present_o)
    else $error("error status with fired id or not last");

  // A query hit is a single, final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && present_o |-> last_o && fired_id_o == 8'd0)
    else $error("query hit not a single result");

  // The engine only takes a command that the queue offers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule

### src/mctt_front.sv
// ----------------------------------------------------------------------------
// mctt_front: item intake and classification
// Accepts input items, turns them into commands and holds them in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module mctt_front #(
  parameter int unsigned IdBits    = 8,
  parameter int unsigned CountBits = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            kind_i,
  input  logic [7:0]            timer_id_i,
  input  logic [31:0]           delay_ticks_i,
  input  logic [31:0]           period_ticks_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_pop_i,
  output mctt_pkg::op_e         cmd_op_o,
  output logic [IdBits-1:0]     cmd_id_o,
  output logic [CountBits-1:0]  cmd_delay_o,
  output logic [CountBits-1:0]  cmd_period_o
);
  import mctt_pkg::*;

  op_e                 q_op_q     [2];
  logic [IdBits-1:0]   q_id_q     [2];
  logic [CountBits-1:0] q_delay_q [2];
  logic [CountBits-1:0] q_period_q[2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          fill_q;
  logic                push;
  logic [IdBits-1:0]   id_in;
  op_e                 op_in;

  assign id_in = IdBits'(timer_id_i);

  always_comb begin
    unique case (kind_i)
      KIND_START:    op_in = (id_in == '0) ? OP_START_NULL : OP_START;
      KIND_STOP:     op_in = OP_STOP;
      KIND_TICK:     op_in = OP_TICK;
      KIND_DISPATCH: op_in = OP_DISPATCH;
      KIND_QUERY:    op_in = (id_in == '0) ? OP_QUERY_NULL : OP_QUERY;
      default:       op_in = OP_NOP;
    endcase
  end

  assign in_stall_o   = fill_q[1];
  assign push         = in_valid_i && !fill_q[1];
  assign cmd_valid_o  = fill_q != 2'd0;
  assign cmd_op_o     = q_op_q[rd_ptr_q];
  assign cmd_id_o     = q_id_q[rd_ptr_q];
  assign cmd_delay_o  = q_delay_q[rd_ptr_q];
  assign cmd_period_o = q_period_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push && !cmd_pop_i) fill_q <= fill_q + 2'd1;
      else if (!push && cmd_pop_i) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_op_q[wr_ptr_q]     <= op_in;
      q_id_q[wr_ptr_q]     <= id_in;
      q_delay_q[wr_ptr_q]  <= CountBits'(delay_ticks_i);
      q_period_q[wr_ptr_q] <= CountBits'(period_ticks_i);
    end
  end

endmodule

### src/mctt_back.sv
// ----------------------------------------------------------------------------
// mctt_back: timer table engine
// Holds the packed timer table in a memory and walks it one slot at a time
// for each table command; collects fired ids and drives the result register.
// ----------------------------------------------------------------------------
module mctt_back #(
  parameter int unsigned MaxEntries = 24,
  parameter int unsigned IdBits     = 8,
  parameter int unsigned CountBits  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  input  mctt_pkg::op_e         cmd_op_i,
  input  logic [IdBits-1:0]     cmd_id_i,
  input  logic [CountBits-1:0]  cmd_delay_i,
  input  logic [CountBits-1:0]  cmd_period_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            fired_id_o,
  output logic                  present_o,
  output logic [1:0]            status_o,
  output logic [4:0]            active_count_o,
  output logic                  last_o
);
  import mctt_pkg::*;

  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned IW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned WW = IdBits + 2 * CountBits;

  logic [WW-1:0]     mem [MaxEntries];
  logic [IdBits-1:0] fire_mem [MaxEntries];

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [IdBits-1:0]    id_q, id_d;
  logic [CountBits-1:0] delay_q, delay_d, period_q, period_d;
  logic [CW-1:0]        i_q, i_d, cnt_q, cnt_d, fcnt_q, fcnt_d, eidx_q, eidx_d;
  logic                 rpres_q, rpres_d;
  logic [1:0]           rstat_q, rstat_d;

  logic [WW-1:0]        rdata_q;
  logic [IdBits-1:0]    fire_rd_q;
  logic                 mem_we, mem_re, fire_we, fire_re;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  logic [WW-1:0]        mem_wdata;

  logic                 ov_q, ov_d;
  logic [7:0]           of_q, of_d;
  logic                 opres_q, opres_d;
  logic [1:0]           os_q, os_d;
  logic [4:0]           oc_q, oc_d;
  logic                 ol_q, ol_d;
  logic                 out_free;

  logic [IdBits-1:0]    e_id;
  logic [CountBits-1:0] e_cnt, e_per;
  logic [CW-1:0]        last_slot;

  assign e_id      = rdata_q[WW-1 -: IdBits];
  assign e_cnt     = rdata_q[2*CountBits-1 -: CountBits];
  assign e_per     = rdata_q[CountBits-1:0];
  assign last_slot = CW'(cnt_q - 1'b1);
  assign out_free  = !ov_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    delay_d   = delay_q;
    period_d  = period_q;
    i_d       = i_q;
    cnt_d     = cnt_q;
    fcnt_d    = fcnt_q;
    eidx_d    = eidx_q;
    rpres_d   = rpres_q;
    rstat_d   = rstat_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = i_q[IW-1:0];
    mem_raddr = i_q[IW-1:0];
    mem_wdata = rdata_q;
    fire_we   = 1'b0;
    fire_re   = 1'b0;
    ov_d      = ov_q && out_stall_i;
    of_d      = of_q;
    opres_d   = opres_q;
    os_d      = os_q;
    oc_d      = oc_q;
    ol_d      = ol_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_op_i;
          id_d      = cmd_id_i;
          delay_d   = cmd_delay_i;
          period_d  = cmd_period_i;
          i_d       = '0;
          fcnt_d    = '0;
          rpres_d   = 1'b0;
          rstat_d   = ST_OK;
          priority case (cmd_op_i)
            OP_START_NULL: begin
              rstat_d = ST_NULL_ID;
              state_d = S_RES;
            end
            OP_QUERY_NULL, OP_NOP: state_d = S_RES;
            default:               state_d = S_RD;
          endcase
        end
      end

      S_RD: begin
        if (i_q >= cnt_q) begin
          // Walk finished without an early exit.
          state_d = S_RES;
          unique case (op_q)
            OP_START: begin
              if (cnt_q < CW'(MaxEntries)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[IW-1:0];
                mem_wdata = {id_q, delay_q, period_q};
                cnt_d     = CW'(cnt_q + 1'b1);
              end else begin
                rstat_d = ST_FULL;
              end
            end
            OP_STOP: rstat_d = ST_NOTFOUND;
            OP_DISPATCH: begin
              if (fcnt_q != '0) begin
                eidx_d  = '0;
                state_d = S_EMRD;
              end
            end
            default: ;
          endcase
        end else begin
          mem_re  = 1'b1;
          state_d = S_EX;
        end
      end

      S_EX: begin
        state_d = S_RD;
        i_d     = CW'(i_q + 1'b1);
        unique case (op_q)
          OP_START: begin
            if (e_id == id_q) begin
              mem_we    = 1'b1;
              mem_wdata = {e_id, delay_q, period_q};
              state_d   = S_RES;
            end
          end
          OP_STOP: begin
            if (e_id == id_q) begin
              if (i_q == last_slot) begin
                cnt_d   = last_slot;
                state_d = S_RES;
              end else begin
                i_d     = i_q;
                state_d = S_RDL;
              end
            end
          end
          OP_TICK: begin
            if (e_cnt != '0) begin
              mem_we    = 1'b1;
              mem_wdata = {e_id, CountBits'(e_cnt - 1'b1), e_per};
            end
          end
          OP_QUERY: begin
            if (e_id == id_q) begin
              rpres_d = 1'b1;
              state_d = S_RES;
            end
          end
          OP_DISPATCH: begin
            if (e_cnt == '0) begin
              fire_we = 1'b1;
              fcnt_d  = CW'(fcnt_q + 1'b1);
              if (e_per != '0) begin
                mem_we    = 1'b1;
                mem_wdata = {e_id, e_per, e_per};
              end else if (i_q == last_slot) begin
                cnt_d = last_slot;
              end else begin
                i_d     = i_q;
                state_d = S_RDL;
              end
            end
          end
          default: ;
        endcase
      end

      S_RDL: begin
        mem_re    = 1'b1;
        mem_raddr = last_slot[IW-1:0];
        state_d   = S_MV;
      end

      S_MV: begin
        // The last entry fills the vacated slot and is not examined again.
        mem_we  = 1'b1;
        cnt_d   = last_slot;
        i_d     = CW'(i_q + 1'b1);
        state_d = (op_q == OP_STOP) ? S_RES : S_RD;
      end

      S_RES: begin
        if (out_free) begin
          ov_d    = 1'b1;
          of_d    = 8'd0;
          opres_d = rpres_q;
          os_d    = rstat_q;
          oc_d    = 5'(cnt_q);
          ol_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_EMRD: begin
        fire_re = 1'b1;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          of_d    = 8'(fire_rd_q);
          opres_d = 1'b0;
          os_d    = ST_OK;
          oc_d    = 5'(cnt_q);
          ol_d    = (eidx_q == CW'(fcnt_q - 1'b1));
          if (eidx_q == CW'(fcnt_q - 1'b1)) begin
            state_d = S_IDLE;
          end else begin
            eidx_d  = CW'(eidx_q + 1'b1);
            state_d = S_EMRD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    delay_q  <= delay_d;
    period_q <= period_d;
    i_q      <= i_d;
    fcnt_q   <= fcnt_d;
    eidx_q   <= eidx_d;
    rpres_q  <= rpres_d;
    rstat_q  <= rstat_d;
    of_q     <= of_d;
    opres_q  <= opres_d;
    os_q     <= os_d;
    oc_q     <= oc_d;
    ol_q     <= ol_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fire_we) fire_mem[fcnt_q[IW-1:0]] <= e_id;
    if (fire_re) fire_rd_q <= fire_mem[eidx_q[IW-1:0]];
  end

  assign out_valid_o    = ov_q;
  assign fired_id_o     = of_q;
  assign present_o      = opres_q;
  assign status_o       = os_q;
  assign active_count_o = oc_q;
  assign last_o         = ol_q;

endmodule

### dv/multi_channel_timer_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_timer_table_checker: result predictor and comparator
// Watches both channels of the timer table, keeps its own copy of the table,
// works out the results of every accepted item and compares them in order.
// ----------------------------------------------------------------------------
module multi_channel_timer_table_checker #(
  parameter int unsigned TableDepth = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  timer_id_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] period_ticks_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  fired_id_i,
  input  logic        present_i,
  input  logic [1:0]  status_i,
  input  logic [4:0]  active_count_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import mctt_pkg::*;

  typedef struct packed {
    logic [7:0] fired_id;
    logic       present;
    logic [1:0] status;
    logic [4:0] active_count;
    logic       last;
  } timer_result_t;

  logic [7:0]  model_id[TableDepth];
  logic [31:0] model_count[TableDepth];
  logic [31:0] model_period[TableDepth];
  int          model_used;
  timer_result_t expected_results[$];

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic int find_timer(input logic [7:0] id);
    for (int i = 0; i < model_used; i++) begin
      if (model_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(input int s);
    int tail;
    tail = model_used - 1;
    if (s != tail) begin
      model_id[s]     = model_id[tail];
      model_count[s]  = model_count[tail];
      model_period[s] = model_period[tail];
    end
    model_used = tail;
  endfunction

  // Applies one item to the model table and queues the results it causes.
  function automatic void predict_timer_step(input logic [2:0] kind, input logic [7:0] id,
                                             input logic [31:0] delay,
                                             input logic [31:0] period);
    timer_result_t step_res[$];
    timer_result_t r;
    int s;
    r = '0;
    case (kind)
      KIND_START: begin
        if (id == 0) begin
          r.status = ST_NULL_ID;
        end else begin
          s = find_timer(id);
          if (s >= 0) begin
            model_count[s]  = delay;
            model_period[s] = period;
          end else if (model_used < TableDepth) begin
            model_id[model_used]     = id;
            model_count[model_used]  = delay;
            model_period[model_used] = period;
            model_used++;
          end else begin
            r.status = ST_FULL;
          end
        end
        step_res.push_back(r);
      end
      KIND_STOP: begin
        s = find_timer(id);
        if (s >= 0) drop_slot(s);
        else r.status = ST_NOTFOUND;
        step_res.push_back(r);
      end
      KIND_TICK: begin
        for (int i = 0; i < model_used; i++) begin
          if (model_count[i] != 0) model_count[i]--;
        end
        step_res.push_back(r);
      end
      KIND_DISPATCH: begin
        // A slot refilled by a removal is skipped until the next pass.
        for (int i = 0; i < model_used; i++) begin
          if (model_count[i] == 0) begin
            r.fired_id = model_id[i];
            step_res.push_back(r);
            if (model_period[i] != 0) model_count[i] = model_period[i];
            else drop_slot(i);
          end
        end
        if (step_res.size() == 0) begin
          r.fired_id = '0;
          step_res.push_back(r);
        end
      end
      KIND_QUERY: begin
        r.present = (id != 0) && (find_timer(id) >= 0);
        step_res.push_back(r);
      end
      default: step_res.push_back(r);
    endcase
    foreach (step_res[k]) begin
      step_res[k].active_count = 5'(model_used);
      step_res[k].last = (k == step_res.size() - 1);
      expected_results.push_back(step_res[k]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t exp_r;
    if (!rst_ni) begin
      model_used = 0;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (fired_id_i !== exp_r.fired_id)
            report_mismatch($sformatf("fired_id %0d, expected %0d", fired_id_i,
                                      exp_r.fired_id));
          if (present_i !== exp_r.present)
            report_mismatch($sformatf("present %0d, expected %0d", present_i,
                                      exp_r.present));
          if (status_i !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i,
                                      exp_r.status));
          if (active_count_i !== exp_r.active_count)
            report_mismatch($sformatf("active_count %0d, expected %0d",
                                      active_count_i, exp_r.active_count));
          if (last_i !== exp_r.last)
            report_mismatch($sformatf("last %0d, expected %0d", last_i, exp_r.last));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_timer_step(kind_i, timer_id_i, delay_ticks_i, period_ticks_i);
    end
  end

endmodule

### dv/multi_channel_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_timer_table_tb: top of the timer table testbench
// Drives directed and random command items into the timer table, stalls the
// result side at random, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module multi_channel_timer_table_tb;
  import mctt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic [7:0]  timer_id_i = '0;
  logic [31:0] delay_ticks_i = '0;
  logic [31:0] period_ticks_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  fired_id_o;
  logic        present_o;
  logic [1:0]  status_o;
  logic [4:0]  active_count_o;
  logic        last_o;

  int fail_count;
  int pending_results;
  int idle_cycles;
  // Set by the sender while the receiver must stay calm, and used to request
  // the long hold-off that fills the intake queue.
  bit quiet_phase;
  bit hold_request;

  always #10 clk_i = ~clk_i;

  multi_channel_timer_table i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .timer_id_i,
    .delay_ticks_i, .period_ticks_i, .out_valid_o, .out_stall_i, .fired_id_o,
    .present_o, .status_o, .active_count_o, .last_o
  );

  multi_channel_timer_table_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .timer_id_i,
    .delay_ticks_i, .period_ticks_i, .out_valid_i(out_valid_o), .out_stall_i,
    .fired_id_i(fired_id_o), .present_i(present_o), .status_i(status_o),
    .active_count_i(active_count_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending_results)
  );

  // Offers one item and holds it until the block takes it. Random gaps are
  // inserted before the item unless the quiet phase is on.
  task automatic send_item(input logic [2:0] kind, input logic [7:0] id,
                           input logic [31:0] delay, input logic [31:0] period);
    logic stalled;
    while (!quiet_phase && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    timer_id_i     <= id;
    delay_ticks_i  <= delay;
    period_ticks_i <= period;
    // The stall only changes at the rising edge, so the value seen at the
    // falling edge is the one that decides the coming edge.
    do begin
      stalled = in_stall_o;
      @(negedge clk_i);
    end while (stalled);
  endtask

  // Picks a timer id from a small pool so that starts, stops and queries
  // usually hit entries that exist.
  function automatic logic [7:0] pool_id();
    return 8'($urandom_range(1, 30));
  endfunction

  // The receiver stalls at random, except in the quiet phase, and holds off
  // for a long counted stretch when the sender asks for it.
  always @(negedge clk_i) begin
    if (hold_request) begin
      out_stall_i <= 1'b1;
      for (int i = 0; i < 300; i++) @(negedge clk_i);
      hold_request = 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !quiet_phase && ($urandom_range(99) < 8);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("multi_channel_timer_table verification failed");
      $finish;
    end
  end

  initial begin
    logic [2:0] k;
    idle_cycles = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: null id, extremes, every kind, full table, ignored kinds.
    send_item(KIND_START, 8'd0, 32'd5, 32'd0);
    send_item(KIND_STOP, 8'd0, '0, '0);
    send_item(KIND_QUERY, 8'd0, '0, '0);
    send_item(KIND_DISPATCH, 8'd7, '0, '0);
    send_item(KIND_START, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_START, 8'd1, 32'd0, 32'd0);
    send_item(KIND_START, 8'd2, 32'd1, 32'd2);
    send_item(KIND_START, 8'd3, 32'd0, 32'd3);
    send_item(KIND_START, 8'd2, 32'd0, 32'd2);
    send_item(KIND_QUERY, 8'd255, '0, '0);
    send_item(KIND_DISPATCH, '0, '0, '0);
    send_item(KIND_TICK, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_STOP, 8'd99, '0, '0);
    send_item(KIND_STOP, 8'd255, '0, '0);
    for (int i = 0; i < 25; i++) send_item(KIND_START, 8'(i + 100), 32'(i % 3), '0);
    send_item(KIND_QUERY, 8'd124, '0, '0);
    send_item(3'd5, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(3'd7, '0, '0, '0);
    send_item(KIND_DISPATCH, '0, '0, '0);

    // Long hold-off while items keep coming, so the intake queue fills up.
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) send_item(KIND_QUERY, 8'(i + 100), '0, '0);

    // Random part: mostly timer traffic on a small id pool with short delays.
    for (int n = 0; n < 330; n++) begin
      quiet_phase = (n >= 150 && n < 200);
      k = 3'($urandom_range(99) < 35 ? KIND_START : $urandom_range(1, 4));
      if ($urandom_range(99) < 3) k = 3'($urandom_range(5, 7));
      if ($urandom_range(99) < 5)
        send_item(k, 8'($urandom), $urandom, $urandom);
      else
        send_item(k, pool_id(), 32'($urandom_range(0, 4)),
                  ($urandom_range(1) ? 32'($urandom_range(1, 5)) : 32'd0));
    end
    in_valid_i <= 1'b0;

    while (pending_results != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("multi_channel_timer_table verification clean");
    end else begin
      $display("multi_channel_timer_table verification failed");
    end
    $finish;
  end

endmodule
